### rtl/core/heart_rate_from_peak_spacing_top_assert.svh
// Assertion macros for the heart rate block and its checker.
// The macros expect a signal named clk, and the first two also rst_n, in the scope where they are used.
`ifndef HEART_RATE_FROM_PEAK_SPACING_TOP_ASSERT_SVH
`define HEART_RATE_FROM_PEAK_SPACING_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define HRPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define HRPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks the reset itself.
`define HRPS_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hrps_pkg.sv
`timescale 1ns / 1ps

package hrps_pkg;

  // Fixed field widths
  localparam int PEAK_W     = 32;
  localparam int BPM_W      = 22;
  localparam int STATUS_W   = 2;
  localparam int RATE_W     = 16;
  // 60 * 65535 fits in 22 bits
  localparam int SCALED_W   = 22;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE = 1'd0;
  localparam logic [RATE_W-1:0]    RATE_RESET      = 16'd360;

  localparam logic [5:0] BPM_SCALE = 6'd60;

  // Parameter defaults
  localparam int WINDOW_DEPTH_DEF = 4;
  localparam int INDEX_WIDTH_DEF  = 32;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_FIRST = 2'd0;
  localparam status_t ST_ZERO  = 2'd1;
  localparam status_t ST_VALID = 2'd2;

endpackage

### rtl/core/hrps_in_if.sv
`timescale 1ns / 1ps

interface hrps_in_if;
  logic                         valid;
  logic                         ready;
  logic [hrps_pkg::PEAK_W-1:0]  peak_index;

  modport source (output valid, output peak_index, input ready);
  modport sink (input valid, input peak_index, output ready);
endinterface

### rtl/core/hrps_out_if.sv
`timescale 1ns / 1ps

interface hrps_out_if;
  logic                        valid;
  logic                        ready;
  logic [hrps_pkg::BPM_W-1:0]  beats_per_minute;
  hrps_pkg::status_t           rate_status;

  modport source (output valid, output beats_per_minute, output rate_status, input ready);
  modport sink (input valid, input beats_per_minute, input rate_status, output ready);
endinterface

### rtl/core/heart_rate_from_peak_spacing_top.sv
`timescale 1ns / 1ps

// Heart rate from R-peak spacing.
// Input channel in_ch: one word per detected R-peak, carrying its sample index.
// Output channel out_ch: one word per input word, with beats_per_minute and
// rate_status (first peak, zero interval ignored, valid rate).
// APB port: register 0 at byte address 0 holds sample_rate (reset 360 Hz);
// write it only while the block is idle. pready is always high.
// Sequence: a first peak or a zero interval goes from idle to the done
// state and then into the output register. A valid rate first sums the
// window entries through one adder, then uses the shared radix-2 divider
// once for the average and, if the average is nonzero, once for the rate;
// with the defaults (window of 4, 32-bit indices) the divider is 34 bits.
// One word is in work at a time; in_ch is ready only while the sequencer
// is idle, so the next peak is taken at the earliest on the edge where the
// previous word can first be drained.
// A finished word sits in the output register; the sequencer may take the
// next input word while it waits, and holds its next result until the
// receiver drains the register.
// Reset (synchronous, active low) clears the peak history, window count and
// output valid, and restores sample_rate to 360.
module heart_rate_from_peak_spacing_top #(
  parameter int WINDOW_DEPTH = hrps_pkg::WINDOW_DEPTH_DEF,
  parameter int INDEX_WIDTH  = hrps_pkg::INDEX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  hrps_in_if.sink                           in_ch,
  hrps_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hrps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [hrps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [hrps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  // Exact sum of the window never wraps.
  localparam int SUM_W = INDEX_WIDTH + $clog2(WINDOW_DEPTH);
  localparam int DIV_W = (SUM_W > hrps_pkg::SCALED_W) ? SUM_W : hrps_pkg::SCALED_W;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_AVG  = 3'd2;
  localparam logic [2:0] S_RATE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic                           have_prev_r;
  logic [INDEX_WIDTH-1:0]         prev_idx_r;
  logic [CNT_W-1:0]               count_r;
  logic [PTR_W-1:0]               ptr_r;
  logic [SUM_W-1:0]               sum_r;
  logic [hrps_pkg::SCALED_W-1:0]  prod_r;
  logic [INDEX_WIDTH-1:0]         window_r [WINDOW_DEPTH];

  logic [hrps_pkg::BPM_W-1:0]     res_bpm_r, res_bpm_nxt;
  hrps_pkg::status_t              res_status_r, res_status_nxt;

  logic                           out_valid_r;
  logic [hrps_pkg::BPM_W-1:0]     out_bpm_r;
  hrps_pkg::status_t              out_status_r;

  logic [hrps_pkg::RATE_W-1:0]    sample_rate;
  logic                           in_acc;
  logic [INDEX_WIDTH-1:0]         idx;
  logic [INDEX_WIDTH-1:0]         gap;
  logic [SUM_W-1:0]               sum_add;
  logic                           sum_last;
  logic                           win_shift;
  logic                           load_out;

  logic                           div_start;
  logic [DIV_W-1:0]               div_num;
  logic [DIV_W-1:0]               div_den;
  logic                           div_done;
  logic [DIV_W-1:0]               div_quo;

  hrps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .sample_rate (sample_rate)
  );

  hrps_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign pready = 1'b1;

  // Accept only while the sequencer is idle.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Interval modulo 2^INDEX_WIDTH, so an index counter wrap is harmless.
  assign idx = in_ch.peak_index[INDEX_WIDTH-1:0];
  assign gap = idx - prev_idx_r;

  // Walk the valid window entries through one adder, newest first.
  assign sum_add  = sum_r + SUM_W'(window_r[ptr_r]);
  assign sum_last = (CNT_W'(ptr_r) == (count_r - 1'b1));

  always_comb begin
    state_nxt      = state_r;
    res_bpm_nxt    = res_bpm_r;
    res_status_nxt = res_status_r;
    win_shift      = 1'b0;
    load_out       = 1'b0;
    div_start      = 1'b0;
    div_num        = '0;
    div_den        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!have_prev_r) begin
            res_bpm_nxt    = '0;
            res_status_nxt = hrps_pkg::ST_FIRST;
            state_nxt      = S_DONE;
          end else if (gap == '0) begin
            // Drop the zero interval; window and count stay as they are.
            res_bpm_nxt    = '0;
            res_status_nxt = hrps_pkg::ST_ZERO;
            state_nxt      = S_DONE;
          end else begin
            win_shift = 1'b1;
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (sum_last) begin
          // Average = sum / count.
          div_start = 1'b1;
          div_num   = DIV_W'(sum_add);
          div_den   = DIV_W'(count_r);
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        if (div_done) begin
          if (div_quo == '0) begin
            res_bpm_nxt    = '0;
            res_status_nxt = hrps_pkg::ST_VALID;
            state_nxt      = S_DONE;
          end else begin
            // Rate = 60 * sample_rate / average.
            div_start = 1'b1;
            div_num   = DIV_W'(prod_r);
            div_den   = div_quo;
            state_nxt = S_RATE;
          end
        end
      end
      S_RATE: begin
        if (div_done) begin
          res_bpm_nxt    = div_quo[hrps_pkg::BPM_W-1:0];
          res_status_nxt = hrps_pkg::ST_VALID;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      prev_idx_r  <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        have_prev_r <= 1'b1;
        prev_idx_r  <= idx;
      end
      // Count saturates at the window depth.
      if (win_shift && (count_r != CNT_W'(WINDOW_DEPTH))) begin
        count_r <= count_r + 1'b1;
      end
      if (win_shift) begin
        ptr_r <= '0;
      end else if (state_r == S_SUM) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_bpm_r    <= res_bpm_nxt;
    res_status_r <= res_status_nxt;
    if (win_shift) begin
      // Advance the window, newest interval in slot 0.
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
        window_r[i] <= window_r[i-1];
      end
      window_r[0] <= gap;
      sum_r       <= '0;
      prod_r      <= hrps_pkg::SCALED_W'(sample_rate) *
                     hrps_pkg::SCALED_W'(hrps_pkg::BPM_SCALE);
    end else if (state_r == S_SUM) begin
      sum_r <= sum_add;
    end
    if (load_out) begin
      out_bpm_r    <= res_bpm_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.beats_per_minute = out_bpm_r;
  assign out_ch.rate_status      = out_status_r;

endmodule

### rtl/core/hrps_cfg.sv
`timescale 1ns / 1ps

module hrps_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hrps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [hrps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [hrps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic [hrps_pkg::RATE_W-1:0]       sample_rate
);

  logic [hrps_pkg::RATE_W-1:0]    sample_rate_r;
  logic [hrps_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[hrps_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == hrps_pkg::REG_SAMPLE_RATE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= hrps_pkg::RATE_RESET;
    end else if (wr_en) begin
      sample_rate_r <= pwdata[hrps_pkg::RATE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == hrps_pkg::REG_SAMPLE_RATE) begin
      prdata = hrps_pkg::CFG_DATA_W'(sample_rate_r);
    end
  end

  assign sample_rate = sample_rate_r;

endmodule

### rtl/core/hrps_div.sv
`timescale 1ns / 1ps

// Restoring radix-2 divider, one quotient bit per cycle.
module hrps_div #(
  parameter int DIV_W = 36
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] den_r;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   den_ext;
  logic [DIV_W:0]   rem_sub;
  logic             fits;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign den_ext = {1'b0, den_r};
  assign fits    = (rem_sh >= den_ext);
  assign rem_sub = rem_sh - den_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/core/hrps_chk.sv
`timescale 1ns / 1ps

`include "heart_rate_from_peak_spacing_top_assert.svh"

module hrps_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hrps_pkg::BPM_W-1:0]  out_bpm,
  input hrps_pkg::status_t           out_status
);

  // A stalled result word stays offered.
  `HRPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped while stalled")

  // A stalled result word keeps its payload.
  `HRPS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bpm) && $stable(out_status), "output payload changed while stalled")

  // Only a valid rate carries a nonzero rate.
  `HRPS_ASSERT_NOW(a_rate_zero, out_valid && (out_status != hrps_pkg::ST_VALID), out_bpm == '0, "nonzero rate without valid status")

  // One word in work at a time: ready drops after each acceptance.
  `HRPS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input accepted while busy")

  // Reset leaves no result word offered.
  `HRPS_ASSERT_ALWAYS_NEXT(a_reset_clear, !rst_n, !out_valid, "output valid after reset")

endmodule

bind heart_rate_from_peak_spacing_top hrps_chk u_hrps_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_bpm    (out_ch.beats_per_minute),
  .out_status (out_ch.rate_status)
);

### tb/sv/heart_rate_from_peak_spacing_top_test.sv
`timescale 1ns / 1ps

// Heart rate block test: drive R-peak sample indices into the input channel,
// predict each rate word in step with acceptance, and compare the output
// channel word for word against the oldest prediction.
module heart_rate_from_peak_spacing_top_test;

  localparam int WINDOW             = hrps_pkg::WINDOW_DEPTH_DEF;
  localparam int SECONDS_PER_MINUTE = 60;
  // Wait after the last rate word, with margin, before touching the register.
  localparam int DRAIN_CYCLES       = 120;
  localparam int HOLD_CYCLES        = 600;
  localparam int RANDOM_PHASES      = 7;
  localparam int PHASE_ITEMS        = 200;
  localparam int MAX_REPORTS        = 40;

  localparam logic [hrps_pkg::REG_IDX_W-1:0]  REG_SPARE        =
    hrps_pkg::REG_SAMPLE_RATE + 1'b1;
  localparam logic [hrps_pkg::CFG_ADDR_W-1:0] SAMPLE_RATE_ADDR =
    {hrps_pkg::REG_SAMPLE_RATE, 2'b00};
  localparam logic [hrps_pkg::CFG_ADDR_W-1:0] SPARE_ADDR       = {REG_SPARE, 2'b00};

  typedef longint unsigned wide_t;

  typedef struct packed {
    logic [hrps_pkg::BPM_W-1:0] bpm;
    hrps_pkg::status_t          status;
  } heart_rate_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [hrps_pkg::CFG_ADDR_W-1:0] paddr;
  logic [hrps_pkg::CFG_DATA_W-1:0] pwdata;
  logic [hrps_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  hrps_in_if  in_ch ();
  hrps_out_if out_ch ();

  heart_rate_from_peak_spacing_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Predictor state: mirrors the block's peak history, spacing window and
  // sample rate register.
  logic [hrps_pkg::RATE_W-1:0] rate_hz;
  logic [hrps_pkg::PEAK_W-1:0] last_index_seen;
  logic                        index_recorded;
  logic [hrps_pkg::PEAK_W-1:0] spacing_window [WINDOW];
  int                          spacing_count;

  heart_rate_t expected_rates [$];

  // Sender and receiver bookkeeping.
  int                          burst_left = 0;
  logic [hrps_pkg::PEAK_W-1:0] last_peak_sent = '0;
  logic [15:0]                 ready_pattern = '1;
  int                          pattern_left = 0;
  logic                        receiver_hold = 1'b0;
  event                        hold_start;
  int                          error_count = 0;
  int                          results_seen = 0;

  // Advance the predictor by one peak and return the rate word it causes.
  function automatic heart_rate_t predict_heart_rate(logic [hrps_pkg::PEAK_W-1:0] peak);
    heart_rate_t rate_word;
    logic [hrps_pkg::PEAK_W-1:0] spacing;
    wide_t total;
    wide_t mean;
    wide_t bpm;
    rate_word.bpm = '0;
    // First peak after reset: record it, no rate yet.
    if (!index_recorded) begin
      index_recorded  = 1'b1;
      last_index_seen = peak;
      rate_word.status = hrps_pkg::ST_FIRST;
      return rate_word;
    end
    // Spacing wraps modulo the index width, so a counter rollover still
    // yields the true spacing.
    spacing = peak - last_index_seen;
    last_index_seen = peak;
    if (spacing == '0) begin
      rate_word.status = hrps_pkg::ST_ZERO;
      return rate_word;
    end
    for (int i = WINDOW - 1; i > 0; i--) spacing_window[i] = spacing_window[i - 1];
    spacing_window[0] = spacing;
    if (spacing_count < WINDOW) spacing_count++;
    // Sum exactly in 64 bits; four full-scale spacings overflow 32.
    total = 0;
    for (int i = 0; i < spacing_count; i++) total += wide_t'(spacing_window[i]);
    mean = total / wide_t'(spacing_count);
    bpm = (mean != 0) ? (wide_t'(SECONDS_PER_MINUTE) * wide_t'(rate_hz)) / mean : 0;
    rate_word.bpm    = bpm[hrps_pkg::BPM_W-1:0];
    rate_word.status = hrps_pkg::ST_VALID;
    return rate_word;
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < MAX_REPORTS) $display("MISMATCH at %0t, word %0d: %s", $time, results_seen, what);
    error_count++;
  endtask

  // Offer one peak word and hold it until accepted. Bursts end in a random
  // gap so that idle cycles land on every phase of the block's work.
  task automatic send_peak(logic [hrps_pkg::PEAK_W-1:0] peak);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 8))
        @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid      <= 1'b1;
    in_ch.peak_index <= peak;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_rates.push_back(predict_heart_rate(peak));
    last_peak_sent = peak;
    burst_left--;
  endtask

  // Drop valid and wait until every expected word is out and the block is idle.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the edge where the access is seen with pready high.
  task automatic write_register(logic [hrps_pkg::CFG_ADDR_W-1:0] addr,
                                logic [hrps_pkg::CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Only register 0 exists; a write elsewhere is dropped.
    if (addr[hrps_pkg::CFG_ADDR_W-1:2] == hrps_pkg::REG_SAMPLE_RATE)
      rate_hz = data[hrps_pkg::RATE_W-1:0];
    @(posedge clk);
  endtask

  // Receiver: check each accepted word, then pick ready from a rotating
  // pattern that is reloaded now and then (all ready, random, sparse, dense).
  always @(posedge clk) begin
    heart_rate_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rates.size() == 0) begin
        report_mismatch("rate word with no peak waiting");
      end else begin
        want = expected_rates.pop_front();
        if (out_ch.beats_per_minute !== want.bpm)
          report_mismatch($sformatf("beats_per_minute %0d, expected %0d",
                                    out_ch.beats_per_minute, want.bpm));
        if (out_ch.rate_status !== want.status)
          report_mismatch($sformatf("rate_status %0d, expected %0d",
                                    out_ch.rate_status, want.status));
      end
      results_seen++;
    end
    if (pattern_left == 0) begin
      case ($urandom_range(3))
        0:       ready_pattern = '1;
        1:       ready_pattern = 16'($urandom);
        2:       ready_pattern = 16'($urandom & $urandom);
        default: ready_pattern = 16'($urandom | $urandom);
      endcase
      if (ready_pattern == '0) ready_pattern = 16'h0001;
      pattern_left = $urandom_range(16, 300);
    end
    pattern_left--;
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    out_ch.ready <= ready_pattern[0] && !receiver_hold;
  end

  // Long receiver hold-off, counted here so the sender keeps running.
  initial begin
    forever begin
      @(hold_start);
      receiver_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      receiver_hold <= 1'b0;
    end
  end

  // First peak, repeated index, and an index counter that rolls over.
  task automatic test_first_peak_and_wrap();
    send_peak(32'hFFFF_FFF0);
    send_peak(32'hFFFF_FFF0);
    send_peak(32'h0000_0010);
    send_peak(32'h0000_0178);
  endtask

  // Highest and lowest rates, full-scale spacings, and a zero sample rate.
  task automatic test_rate_extremes();
    settle_block();
    write_register(SAMPLE_RATE_ADDR, 32'h0000_FFFF);
    // Spacing of one sample at the top rate gives the largest word.
    repeat (WINDOW) send_peak(last_peak_sent + 32'd1);
    // Full-scale spacings: the window sum needs more than 32 bits.
    repeat (WINDOW) send_peak(last_peak_sent + 32'hFFFF_FFFF);
    settle_block();
    write_register(SAMPLE_RATE_ADDR, 32'd1);
    send_peak(last_peak_sent + 32'd60);
    send_peak(last_peak_sent + 32'd1);
    settle_block();
    write_register(SAMPLE_RATE_ADDR, 32'd0);
    send_peak(last_peak_sent + 32'd300);
    send_peak(last_peak_sent + 32'd300);
  endtask

  // Unused register address and upper data bits are both ignored.
  task automatic test_register_decode();
    settle_block();
    write_register(SPARE_ADDR, '1);
    write_register(SAMPLE_RATE_ADDR,
                   32'hABCD_0000 | hrps_pkg::CFG_DATA_W'(hrps_pkg::RATE_RESET));
    repeat (3) send_peak(last_peak_sent + $urandom_range(200, 500));
  endtask

  // Stall the receiver for a long stretch while peaks keep coming, so the
  // block fills up and holds off its input.
  task automatic test_long_receiver_stall();
    settle_block();
    burst_left = 40;
    -> hold_start;
    repeat (40) send_peak(last_peak_sent + $urandom_range(200, 400));
  endtask

  // Mostly plausible rhythms with random spacing, some short, zero and
  // full-scale spacings, and some unrelated indices, over several rates.
  task automatic test_random_rhythm();
    logic [hrps_pkg::PEAK_W-1:0] spacing;
    logic [hrps_pkg::CFG_DATA_W-1:0] rate_value;
    int pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       rate_value = hrps_pkg::CFG_DATA_W'(hrps_pkg::RATE_RESET);
        1:       rate_value = 32'd1;
        2:       rate_value = 32'h0000_FFFF;
        3:       rate_value = 32'd0;
        4:       rate_value = $urandom;
        5:       rate_value = $urandom_range(100, 1000);
        default: rate_value = hrps_pkg::CFG_DATA_W'(hrps_pkg::RATE_RESET);
      endcase
      settle_block();
      write_register(SAMPLE_RATE_ADDR, rate_value);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 65)      spacing = $urandom_range(100, 2000);
        else if (pick < 75) spacing = $urandom_range(1, 16);
        else if (pick < 82) spacing = '0;
        else if (pick < 90) spacing = $urandom;
        else if (pick < 95) spacing = 32'hFFFF_FFFF - $urandom_range(0, 4000);
        else                spacing = $urandom - last_peak_sent;
        send_peak(last_peak_sent + spacing);
      end
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.peak_index = '0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rate_hz          = hrps_pkg::RATE_RESET;
    last_index_seen  = '0;
    index_recorded   = 1'b0;
    spacing_count    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_peak_and_wrap();
    test_rate_extremes();
    test_register_decode();
    test_long_receiver_stall();
    test_random_rhythm();
    settle_block();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
